### src/sad_pkg.sv
// Shared types and constants for the segment versus box slab test.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package sad_pkg;

  localparam int unsigned NumAxes  = 3;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned NumW     = DiffW + 16;
  localparam int unsigned QuotBits = 31;
  // Overflow check stage, one stage per quotient bit, and the sign fix stage.
  localparam int unsigned DivLat   = QuotBits + 2;

  localparam logic [2:0] NormNone = 3'd0;
  localparam logic [2:0] NormNegX = 3'd1;
  localparam logic [2:0] NormPosX = 3'd2;
  localparam logic [2:0] NormNegY = 3'd3;
  localparam logic [2:0] NormPosY = 3'd4;
  localparam logic [2:0] NormNegZ = 3'd5;
  localparam logic [2:0] NormPosZ = 3'd6;

  localparam logic signed [CoordW-1:0] TOne   = 32'sd65536;
  localparam logic signed [CoordW-1:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [CoordW-1:0] SatMin = 32'sh8000_0000;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [DiffW-1:0]  diff_t;
  typedef logic [NumW-1:0]   num_t;

  typedef struct packed {
    logic               valid;
    logic [NumAxes-1:0] par;
    logic [NumAxes-1:0] pmiss;
  } side_t;

endpackage

### src/sad_front.sv
// Front end: direction and slab offsets, then magnitudes and the parallel test.
// Two register stages. Depends on sad_pkg.
`timescale 1ns / 1ps

module sad_front (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [15:0]                                thr_i,
  input  sad_pkg::coord_t [sad_pkg::NumAxes-1:0]     start_i,
  input  sad_pkg::coord_t [sad_pkg::NumAxes-1:0]     end_i,
  input  sad_pkg::coord_t [sad_pkg::NumAxes-1:0]     lo_i,
  input  sad_pkg::coord_t [sad_pkg::NumAxes-1:0]     hi_i,
  output sad_pkg::num_t   [sad_pkg::NumAxes-1:0]     num1_o,
  output sad_pkg::num_t   [sad_pkg::NumAxes-1:0]     num2_o,
  output logic            [sad_pkg::NumAxes-1:0]     neg1_o,
  output logic            [sad_pkg::NumAxes-1:0]     neg2_o,
  output sad_pkg::diff_t  [sad_pkg::NumAxes-1:0]     den_o,
  output sad_pkg::side_t                             side_o
);

  sad_pkg::diff_t [sad_pkg::NumAxes-1:0] d_q, d_d, n1_q, n1_d, n2_q, n2_d;
  logic valid_a_q;

  sad_pkg::num_t  [sad_pkg::NumAxes-1:0] num1_d, num2_d, num1_q, num2_q;
  logic           [sad_pkg::NumAxes-1:0] neg1_d, neg2_d, neg1_q, neg2_q;
  sad_pkg::diff_t [sad_pkg::NumAxes-1:0] den_d, den_q;
  sad_pkg::side_t side_d, side_q;

  always_comb begin
    for (int a = 0; a < sad_pkg::NumAxes; a++) begin
      d_d[a]  = {end_i[a][31], end_i[a]} - {start_i[a][31], start_i[a]};
      n1_d[a] = {lo_i[a][31], lo_i[a]} - {start_i[a][31], start_i[a]};
      n2_d[a] = {hi_i[a][31], hi_i[a]} - {start_i[a][31], start_i[a]};
    end
  end

  always_comb begin
    sad_pkg::diff_t m1, m2;
    side_d.valid = valid_a_q;
    for (int a = 0; a < sad_pkg::NumAxes; a++) begin
      den_d[a] = d_q[a][32] ? -d_q[a] : d_q[a];
      m1 = n1_q[a][32] ? -n1_q[a] : n1_q[a];
      m2 = n2_q[a][32] ? -n2_q[a] : n2_q[a];
      num1_d[a] = {m1, 16'b0};
      num2_d[a] = {m2, 16'b0};
      neg1_d[a] = n1_q[a][32] ^ d_q[a][32];
      neg2_d[a] = n2_q[a][32] ^ d_q[a][32];
      side_d.par[a] = den_d[a] <= {17'b0, thr_i};
      // Start below the slab minimum or above its maximum.
      side_d.pmiss[a] = side_d.par[a] &&
                        ((!n1_q[a][32] && (n1_q[a] != '0)) || n2_q[a][32]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      side_q    <= '0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      side_q    <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q          <= d_d;
      n1_q         <= n1_d;
      n2_q         <= n2_d;
      num1_q       <= num1_d;
      num2_q       <= num2_d;
      neg1_q       <= neg1_d;
      neg2_q       <= neg2_d;
      den_q        <= den_d;
    end
  end

  assign num1_o = num1_q;
  assign num2_o = num2_q;
  assign neg1_o = neg1_q;
  assign neg2_o = neg2_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule

### src/sad_divider.sv
// Pipelined restoring divider, one quotient bit per stage, truncating and
// saturating to signed 32 bits. Depends on sad_pkg.
`timescale 1ns / 1ps

module sad_divider (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  sad_pkg::num_t         num_i,
  input  sad_pkg::diff_t        den_i,
  input  logic                  neg_i,
  output logic signed [31:0]    quot_o
);

  localparam int unsigned Nb = sad_pkg::QuotBits;
  localparam int unsigned Cw = sad_pkg::NumW + 15;

  sad_pkg::num_t  rem_q [Nb+1];
  sad_pkg::diff_t den_q [Nb+1];
  logic [Nb-1:0]  quo_q [Nb+1];
  logic           neg_q [Nb+1];
  logic           ovf_q [Nb+1];
  logic signed [31:0] out_q;

  // A quotient of 2^31 or more saturates; the rest fits in the stage bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      ovf_q[0] <= {{(Cw-sad_pkg::NumW){1'b0}}, num_i} >= {den_i, {Nb{1'b0}}};
    end
  end

  for (genvar k = 1; k <= Nb; k++) begin : g_stage
    localparam int unsigned Bit = Nb - k;
    logic [Cw-1:0] sh;
    logic          ge;
    assign sh = {{(Cw-sad_pkg::DiffW){1'b0}}, den_q[k-1]} << Bit;
    assign ge = {{(Cw-sad_pkg::NumW){1'b0}}, rem_q[k-1]} >= sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_q[k-1] - sh[sad_pkg::NumW-1:0] : rem_q[k-1];
        quo_q[k] <= quo_q[k-1] | ({{(Nb-1){1'b0}}, ge} << Bit);
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ovf_q[Nb]) begin
        out_q <= neg_q[Nb] ? sad_pkg::SatMin : sad_pkg::SatMax;
      end else begin
        out_q <= neg_q[Nb] ? -$signed({1'b0, quo_q[Nb]}) : $signed({1'b0, quo_q[Nb]});
      end
    end
  end

  assign quot_o = out_q;

endmodule

### src/sad_fold.sv
// Per-axis ordering of entry and exit, then the fold over X, Y and Z into
// hit, entry parameter and face code. One register stage. Depends on sad_pkg.
`timescale 1ns / 1ps

module sad_fold (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  sad_pkg::side_t                              side_i,
  input  logic signed [sad_pkg::NumAxes-1:0][31:0]    t1_i,
  input  logic signed [sad_pkg::NumAxes-1:0][31:0]    t2_i,
  output logic                                        valid_o,
  output logic                                        hit_o,
  output logic [16:0]                                 param_o,
  output logic [2:0]                                  code_o
);

  logic signed [sad_pkg::NumAxes-1:0][31:0] near_q, far_q;
  logic [sad_pkg::NumAxes-1:0][2:0]         code_q;
  sad_pkg::side_t                           side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < sad_pkg::NumAxes; a++) begin
        // Swapping puts the entry on the plus face of this axis.
        if ($signed(t1_i[a]) > $signed(t2_i[a])) begin
          near_q[a] <= t2_i[a];
          far_q[a]  <= t1_i[a];
          code_q[a] <= sad_pkg::NormNegX + 3'(2 * a) + 3'd1;
        end else begin
          near_q[a] <= t1_i[a];
          far_q[a]  <= t2_i[a];
          code_q[a] <= sad_pkg::NormNegX + 3'(2 * a);
        end
      end
    end
  end

  // Entry only grows and exit only shrinks, so one check at the end is enough.
  always_comb begin
    logic signed [31:0] tmin, tmax;
    logic [2:0]         norm;
    tmin = '0;
    tmax = sad_pkg::TOne;
    norm = sad_pkg::NormNone;
    for (int a = 0; a < sad_pkg::NumAxes; a++) begin
      if (!side_q.par[a]) begin
        if ($signed(near_q[a]) > tmin) begin
          tmin = near_q[a];
          norm = code_q[a];
        end
        if ($signed(far_q[a]) < tmax) begin
          tmax = far_q[a];
        end
      end
    end
    hit_o   = (side_q.pmiss == '0) && (tmin <= tmax);
    param_o = hit_o ? tmin[16:0] : 17'd0;
    code_o  = hit_o ? norm : sad_pkg::NormNone;
  end

  assign valid_o = side_q.valid;

endmodule

### src/segment_aabb_slab_intersect_core.sv
// Top level of the segment versus axis-aligned box slab test.
// Uses sad_pkg, sad_front, sad_divider and sad_fold.
//
//   channel  direction  handshake          payload
//   input    in         in_valid_i/stall_o  start, end, box min/max (12 x 32 bit)
//   result   out        valid_o/stall_i     hit, hit_param, normal_code
//   config   in         thr_we_i            near_zero_threshold (16 bit)
//
// One item is accepted every cycle while the result is not stalled; each gives one
// result after two front stages, 33 stages of the six parallel bit-per-stage
// dividers, one ordering stage and the output register. Reset clears the valid bits
// and sets the threshold to 66. A stalled result freezes the whole pipeline.
`timescale 1ns / 1ps

module segment_aabb_slab_intersect_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               thr_we_i,
  input  logic [15:0]        thr_wdata_i,
  input  logic               in_valid_i,
  output logic               stall_o,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic signed [31:0] end_z_i,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_min_z_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  input  logic signed [31:0] box_max_z_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               hit_o,
  output logic [16:0]        hit_param_o,
  output logic [2:0]         normal_code_o
);

  localparam int unsigned Na = sad_pkg::NumAxes;

  logic        en;
  logic [15:0] thr_q;

  sad_pkg::num_t  [Na-1:0] num1, num2;
  logic           [Na-1:0] neg1, neg2;
  sad_pkg::diff_t [Na-1:0] den;
  sad_pkg::side_t          side_front;
  sad_pkg::side_t          side_q [sad_pkg::DivLat];
  logic signed [Na-1:0][31:0] t1, t2;

  logic        f_valid, f_hit;
  logic [16:0] f_param;
  logic [2:0]  f_code;
  logic        out_valid_q, hit_q;
  logic [16:0] param_q;
  logic [2:0]  code_q;

  assign en      = !(out_valid_q && stall_i);
  assign stall_o = out_valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd66;
    end else if (thr_we_i) begin
      thr_q <= thr_wdata_i;
    end
  end

  sad_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .thr_i   (thr_q),
    .start_i ({start_z_i, start_y_i, start_x_i}),
    .end_i   ({end_z_i, end_y_i, end_x_i}),
    .lo_i    ({box_min_z_i, box_min_y_i, box_min_x_i}),
    .hi_i    ({box_max_z_i, box_max_y_i, box_max_x_i}),
    .num1_o  (num1),
    .num2_o  (num2),
    .neg1_o  (neg1),
    .neg2_o  (neg2),
    .den_o   (den),
    .side_o  (side_front)
  );

  for (genvar a = 0; a < Na; a++) begin : g_axis
    sad_divider u_div1 (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num1[a]),
      .den_i  (den[a]),
      .neg_i  (neg1[a]),
      .quot_o (t1[a])
    );
    sad_divider u_div2 (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num2[a]),
      .den_i  (den[a]),
      .neg_i  (neg2[a]),
      .quot_o (t2[a])
    );
  end

  // Parallel flags and valid bits travel beside the dividers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < sad_pkg::DivLat; k++) begin
        side_q[k] <= '0;
      end
    end else if (en) begin
      side_q[0] <= side_front;
      for (int k = 1; k < sad_pkg::DivLat; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  sad_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .side_i  (side_q[sad_pkg::DivLat-1]),
    .t1_i    (t1),
    .t2_i    (t2),
    .valid_o (f_valid),
    .hit_o   (f_hit),
    .param_o (f_param),
    .code_o  (f_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= f_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= f_hit;
      param_q <= f_param;
      code_q  <= f_code;
    end
  end

  assign valid_o       = out_valid_q;
  assign hit_o         = hit_q;
  assign hit_param_o   = param_q;
  assign normal_code_o = code_q;

endmodule
